>>> sv/mqfw_pkg.sv
package mqfw_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int NUM_QUEUES  = 4;
  localparam int RECORD_BITS = 64;
  localparam int MAX_BATCH   = 64;

  // Derived widths.
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int BW = $clog2(MAX_BATCH + 1);

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int SEL_W     = 2;
  localparam int DATA_W    = 64;
  localparam int REQ_W     = 7;
  localparam int KIND_W    = 2;
  localparam int SRC_W     = 2;
  localparam int CNT_W     = 32;
  localparam int MARK_W    = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [MARK_W-1:0] HIGH_MARK_RST = MARK_W'(QUEUE_DEPTH * 4 / 5);
  localparam logic [MARK_W-1:0] LOW_MARK_RST  = MARK_W'(QUEUE_DEPTH * 3 / 5);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_REC   = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_MARK = 1'b0,
    REG_LOW_MARK  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_CLEAR,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic latch_in;
    logic do_put;
    logic do_clear;
    logic rd_issue;
    logic scan_next;
    logic emit_rec;
    logic emit_empty;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] in_cmd;
    logic             in_valid;
    logic             out_free;
    logic             fill_nz;
    logic             scan_last;
    logic             want_zero;
    logic             rec_last;
  } status_t;

endpackage

>>> sv/mqfw_if.sv
interface mqfw_in_if;
  import mqfw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SEL_W-1:0]  queue_select;
  logic [DATA_W-1:0] payload;
  logic [REQ_W-1:0]  request_count;

  modport source (output valid, cmd, queue_select, payload, request_count, input ready);
  modport sink   (input valid, cmd, queue_select, payload, request_count, output ready);
endinterface

interface mqfw_out_if;
  import mqfw_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              accepted;
  logic              alarm;
  logic [DATA_W-1:0] payload_res;
  logic [SRC_W-1:0]  source_queue;
  logic              last;
  logic [CNT_W-1:0]  dropped_count;
  logic [CNT_W-1:0]  put_count;
  logic [CNT_W-1:0]  got_count;

  modport source (output valid, kind, accepted, alarm, payload_res, source_queue, last,
                  dropped_count, put_count, got_count, input ready);
  modport sink   (input valid, kind, accepted, alarm, payload_res, source_queue, last,
                  dropped_count, put_count, got_count, output ready);
endinterface

interface mqfw_cfg_if;
  import mqfw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [MARK_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> sv/mqfw_ctrl.sv
module mqfw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  mqfw_pkg::status_t status,
  output mqfw_pkg::ctl_t    ctl
);
  import mqfw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (status.in_valid) begin
          ctl.latch_in = 1'b1;
          unique case (status.in_cmd)
            CMD_PUT:   state_nxt = ST_PUT;
            CMD_GET:   state_nxt = ST_SCAN;
            CMD_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUT: begin
        if (status.out_free) begin
          ctl.do_put = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (status.out_free) begin
          ctl.do_clear = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // A batch that has emitted records always ends in the emit state, so
        // running off the last queue here means nothing was drained.
        priority if (status.want_zero) begin
          state_nxt = ST_EMPTY;
        end else if (status.fill_nz) begin
          ctl.rd_issue = 1'b1;
          state_nxt    = ST_EMIT;
        end else if (status.scan_last) begin
          state_nxt = ST_EMPTY;
        end else begin
          ctl.scan_next = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          ctl.emit_rec = 1'b1;
          state_nxt    = status.rec_last ? ST_IDLE : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          ctl.emit_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> sv/mqfw_datapath.sv
module mqfw_datapath (
  input  logic              clk,
  input  logic              rst_n,
  mqfw_in_if.sink           in_bus,
  mqfw_out_if.source        out_bus,
  mqfw_cfg_if.sink          cfg_bus,
  input  mqfw_pkg::ctl_t    ctl,
  output mqfw_pkg::status_t status
);
  import mqfw_pkg::*;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (PW'(p) == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] rec_addr(input logic [QW-1:0] q, input logic [PW-1:0] p);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  // Latched request.
  cmd_t                   cmd_r;
  logic [SEL_W-1:0]       sel_r;
  logic [RECORD_BITS-1:0] data_r;
  logic [BW-1:0]          want_r;

  // Queue state.
  logic [PW-1:0]         wp_r   [NUM_QUEUES];
  logic [PW-1:0]         wp_nxt [NUM_QUEUES];
  logic [PW-1:0]         rp_r   [NUM_QUEUES];
  logic [PW-1:0]         rp_nxt [NUM_QUEUES];
  logic [FW-1:0]         fill_r   [NUM_QUEUES];
  logic [FW-1:0]         fill_nxt [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] alarm_r, alarm_nxt;
  logic [QW-1:0]         scan_q_r, scan_q_nxt;
  logic [BW-1:0]         n_r, n_nxt;

  logic [MARK_W-1:0] high_r, high_nxt, low_r, low_nxt;
  logic [CNT_W-1:0]  dropped_r, dropped_nxt, put_r, put_nxt, got_r, got_nxt;

  // Record store and its registered read port.
  logic [RECORD_BITS-1:0] mem [NUM_QUEUES * QUEUE_DEPTH];
  logic [RECORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic                   mem_we;

  // Output stage.
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  kind_t             o_kind_r, o_kind_nxt;
  logic              o_acc_r, o_acc_nxt;
  logic              o_alarm_r, o_alarm_nxt;
  logic [DATA_W-1:0] o_data_r, o_data_nxt;
  logic [SRC_W-1:0]  o_src_r, o_src_nxt;
  logic              o_last_r, o_last_nxt;

  logic [QW-1:0]  put_q;
  logic           sel_ok;
  logic [FW-1:0]  put_fill, fill_new;
  logic           room, alarm_new;
  logic           more_left;
  logic [BW-1:0]  n_inc;
  logic [REQ_W-1:0] req_in;

  assign in_bus.ready  = ctl.in_ready;
  assign cfg_bus.ready = 1'b1;

  assign put_q    = QW'(sel_r);
  assign sel_ok   = (32'(sel_r) < NUM_QUEUES);
  assign put_fill = fill_r[put_q];
  assign room     = (put_fill < FW'(QUEUE_DEPTH));
  assign fill_new = room ? put_fill + 1'b1 : put_fill;
  // Hysteresis: a raised alarm waits for the low mark, a clear one for the high mark.
  assign alarm_new = alarm_r[put_q] ?
      !({{MARK_W{1'b0}}, fill_new} < {{FW{1'b0}}, low_r}) :
      ({{MARK_W{1'b0}}, fill_new} > {{FW{1'b0}}, high_r});

  assign mem_we  = ctl.do_put && sel_ok && room;
  assign wr_addr = rec_addr(put_q, wp_r[put_q]);
  assign rd_addr = rec_addr(scan_q_r, rp_r[scan_q_r]);

  assign n_inc = n_r + 1'b1;

  always_comb begin
    more_left = (fill_r[scan_q_r] > FW'(1));
    for (int j = 0; j < NUM_QUEUES; j++) begin
      if ((QW'(j) > scan_q_r) && (fill_r[j] != '0)) begin
        more_left = 1'b1;
      end
    end
  end

  assign req_in = in_bus.request_count;

  assign status.in_cmd    = in_bus.cmd;
  assign status.in_valid  = in_bus.valid;
  assign status.out_free  = !out_valid_r || out_bus.ready;
  assign status.fill_nz   = (fill_r[scan_q_r] != '0);
  assign status.scan_last = (scan_q_r == QW'(NUM_QUEUES - 1));
  assign status.want_zero = (want_r == '0);
  assign status.rec_last  = (n_inc == want_r) || !more_left;

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    alarm_nxt   = alarm_r;
    scan_q_nxt  = scan_q_r;
    n_nxt       = n_r;
    dropped_nxt = dropped_r;
    put_nxt     = put_r;
    got_nxt     = got_r;
    high_nxt    = high_r;
    low_nxt     = low_r;
    out_load    = 1'b0;
    o_kind_nxt  = o_kind_r;
    o_acc_nxt   = 1'b0;
    o_alarm_nxt = 1'b0;
    o_data_nxt  = '0;
    o_src_nxt   = '0;
    o_last_nxt  = 1'b1;

    if (cfg_bus.valid) begin
      unique case (cfg_reg_t'(cfg_bus.reg_index))
        REG_HIGH_MARK: high_nxt = cfg_bus.wdata;
        REG_LOW_MARK:  low_nxt  = cfg_bus.wdata;
        default: ;
      endcase
    end

    if (ctl.latch_in) begin
      scan_q_nxt = '0;
      n_nxt      = '0;
    end

    if (ctl.scan_next) begin
      scan_q_nxt = scan_q_r + 1'b1;
    end

    if (ctl.do_put) begin
      out_load   = 1'b1;
      o_kind_nxt = KIND_PUT;
      o_src_nxt  = sel_r;
      if (sel_ok) begin
        if (room) begin
          wp_nxt[put_q]   = ptr_inc(wp_r[put_q]);
          fill_nxt[put_q] = fill_new;
          put_nxt         = sat_inc(put_r);
          o_acc_nxt       = 1'b1;
        end else begin
          dropped_nxt = sat_inc(dropped_r);
        end
        alarm_nxt[put_q] = alarm_new;
        o_alarm_nxt      = alarm_new;
      end
    end

    if (ctl.do_clear) begin
      for (int j = 0; j < NUM_QUEUES; j++) begin
        wp_nxt[j]   = '0;
        rp_nxt[j]   = '0;
        fill_nxt[j] = '0;
      end
      alarm_nxt   = '0;
      dropped_nxt = '0;
      put_nxt     = '0;
      got_nxt     = '0;
      out_load    = 1'b1;
      o_kind_nxt  = KIND_CLEAR;
    end

    if (ctl.emit_rec) begin
      rp_nxt[scan_q_r]   = ptr_inc(rp_r[scan_q_r]);
      fill_nxt[scan_q_r] = fill_r[scan_q_r] - 1'b1;
      got_nxt            = sat_inc(got_r);
      n_nxt              = n_inc;
      out_load           = 1'b1;
      o_kind_nxt         = KIND_REC;
      o_data_nxt         = DATA_W'(rd_data_r);
      o_src_nxt          = SRC_W'(scan_q_r);
      o_last_nxt         = status.rec_last;
    end

    if (ctl.emit_empty) begin
      out_load   = 1'b1;
      o_kind_nxt = KIND_EMPTY;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_QUEUES; j++) begin
        wp_r[j]   <= '0;
        rp_r[j]   <= '0;
        fill_r[j] <= '0;
      end
      alarm_r     <= '0;
      scan_q_r    <= '0;
      n_r         <= '0;
      dropped_r   <= '0;
      put_r       <= '0;
      got_r       <= '0;
      high_r      <= HIGH_MARK_RST;
      low_r       <= LOW_MARK_RST;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      alarm_r     <= alarm_nxt;
      scan_q_r    <= scan_q_nxt;
      n_r         <= n_nxt;
      dropped_r   <= dropped_nxt;
      put_r       <= put_nxt;
      got_r       <= got_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r  <= cmd_t'(in_bus.cmd);
      sel_r  <= in_bus.queue_select;
      data_r <= RECORD_BITS'(in_bus.payload);
      want_r <= (req_in > REQ_W'(MAX_BATCH)) ? BW'(MAX_BATCH) : BW'(req_in);
    end
    if (out_load) begin
      o_kind_r  <= o_kind_nxt;
      o_acc_r   <= o_acc_nxt;
      o_alarm_r <= o_alarm_nxt;
      o_data_r  <= o_data_nxt;
      o_src_r   <= o_src_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  // The output counters follow the live totals, which only move on a load.
  logic [CNT_W-1:0] o_dropped_r, o_put_r, o_got_r;
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_dropped_r <= dropped_nxt;
      o_put_r     <= put_nxt;
      o_got_r     <= got_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && (cmd_r == CMD_PUT)) begin
      mem[wr_addr] <= data_r;
    end
    if (ctl.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.kind          = o_kind_r;
  assign out_bus.accepted      = o_acc_r;
  assign out_bus.alarm         = o_alarm_r;
  assign out_bus.payload_res   = o_data_r;
  assign out_bus.source_queue  = o_src_r;
  assign out_bus.last          = o_last_r;
  assign out_bus.dropped_count = o_dropped_r;
  assign out_bus.put_count     = o_put_r;
  assign out_bus.got_count     = o_got_r;

endmodule

>>> sv/multi_queue_fifo_watermark.sv
// Four record FIFOs sharing one store, with a per-queue fill alarm
// that is raised above high_mark and cleared below low_mark. Requests are taken
// one at a time: a put or a clear is accepted, then updates the queues and
// loads its result, and a get is accepted and then drains each record with a
// registered store read and then its result, passing over empty queues while
// scanning in index order. A get that drains nothing checks each queue in turn
// (none when it asks for no records) and then loads its empty result. The
// result register decouples the two sides, so a waiting result only holds up
// the next one. The store is never cleared; the pointers only ever reach
// entries already written. Configuration writes are always taken and belong in
// idle periods.
module multi_queue_fifo_watermark (
  input logic        clk,
  input logic        rst_n,
  mqfw_in_if.sink    in_bus,
  mqfw_out_if.source out_bus,
  mqfw_cfg_if.sink   cfg_bus
);
  import mqfw_pkg::*;

  ctl_t    ctl;
  status_t status;

  mqfw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl)
  );

  mqfw_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus),
    .ctl     (ctl),
    .status  (status)
  );

endmodule
